// File: design/cvt_pkg.sv
`timescale 1ns / 1ps

package cvt_pkg;

  // Number of implemented controller registers (indexes at or above read as zero)
  localparam int CrtcRegs = 32;
  localparam int IdxW     = 5;

  // Bus ports
  localparam logic [15:0] PortIndex  = 16'h03d4;
  localparam logic [15:0] PortData   = 16'h03d5;
  localparam logic [15:0] PortStatus = 16'h03da;
  localparam logic [15:0] PortArray  = 16'h03de;

  // Array entry that holds the wide addressing mode
  localparam logic [IdxW-1:0] ArrayWide = 5'd5;

  localparam logic [15:0] StartMask   = 16'h3fff;
  localparam logic [7:0]  BlinkSelMsk = 8'h60;
  localparam logic [7:0]  BlinkOff    = 8'h20;
  localparam logic [4:0]  VsyncLines  = 5'd16;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  // Timing registers seen by the vertical counters
  typedef struct packed {
    logic [7:0] r1;
    logic [7:0] r4;
    logic [7:0] r5;
    logic [7:0] r6;
    logic [7:0] r7;
    logic [7:0] r8;
    logic [7:0] r9;
    logic [7:0] r10;
    logic [7:0] r11;
    logic [7:0] r12;
    logic [7:0] r13;
    logic       wide_mode;
  } cfg_t;

  // Visible timing state after an update
  typedef struct packed {
    logic        display_on;
    logic [4:0]  scan_line;
    logic [7:0]  char_row;
    logic [15:0] char_address;
    logic        cursor_visible;
    logic [3:0]  status_bits;
  } timing_t;

  // Writable bits of each controller register
  function automatic logic [7:0] reg_mask(input logic [IdxW-1:0] idx);
    logic [7:0] m;
    case (idx)
      5'd5, 5'd9, 5'd11: m = 8'h1f;
      5'd8:              m = 8'hf3;
      5'd10:             m = 8'h7f;
      5'd12, 5'd14:      m = 8'h3f;
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd6, 5'd7,
      5'd13, 5'd15, 5'd16, 5'd17: m = 8'hff;
      default:           m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// File: design/cvt_regfile.sv
`timescale 1ns / 1ps

module cvt_regfile (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [15:0]        port,
  input  logic [7:0]         value,
  output cvt_pkg::cfg_t      cfg,
  output logic [4:0]         crtc_index,
  output logic [7:0]         rd_data
);
  import cvt_pkg::*;

  logic [7:0]      crtc_file [32];
  logic [IdxW-1:0] table_index;
  logic            wide_mode;
  logic            idx_ok;

  assign idx_ok = {1'b0, crtc_index} < 6'(CrtcRegs);

  // Apply bus writes to the index, register file and array ports
  always_ff @(posedge clk) begin
    if (rst) begin
      crtc_index  <= '0;
      table_index <= '0;
      wide_mode   <= 1'b0;
      for (int i = 0; i < 32; i++) begin
        crtc_file[i] <= '0;
      end
    end else if (wr_en) begin
      case (port)
        PortIndex:  crtc_index <= value[IdxW-1:0];
        PortData: begin
          if (idx_ok) begin
            crtc_file[crtc_index] <= value & reg_mask(crtc_index);
          end
        end
        PortStatus: table_index <= value[IdxW-1:0];
        PortArray: begin
          if (table_index == ArrayWide) begin
            wide_mode <= value[0];
          end
        end
        default: ;
      endcase
    end
  end

  // Read at the current index
  assign rd_data = idx_ok ? crtc_file[crtc_index] : 8'h00;

  // Fixed taps for the vertical timing
  assign cfg.r1        = crtc_file[1];
  assign cfg.r4        = crtc_file[4];
  assign cfg.r5        = crtc_file[5];
  assign cfg.r6        = crtc_file[6];
  assign cfg.r7        = crtc_file[7];
  assign cfg.r8        = crtc_file[8];
  assign cfg.r9        = crtc_file[9];
  assign cfg.r10       = crtc_file[10];
  assign cfg.r11       = crtc_file[11];
  assign cfg.r12       = crtc_file[12];
  assign cfg.r13       = crtc_file[13];
  assign cfg.wide_mode = wide_mode;

endmodule

// File: design/cvt_timing.sv
`timescale 1ns / 1ps

module cvt_timing (
  input  logic             clk,
  input  logic             rst,
  input  logic             tick_en,
  input  cvt_pkg::cfg_t    cfg,
  output logic [3:0]       status_cur,
  output cvt_pkg::timing_t nxt
);
  import cvt_pkg::*;

  logic        line_phase,      line_phase_next;
  logic [4:0]  scan_line,       scan_line_next;
  logic [7:0]  char_row,        char_row_next;
  logic [4:0]  adjust_left,     adjust_left_next;
  logic [4:0]  vsync_left,      vsync_left_next;
  logic [15:0] char_address,    char_address_next;
  logic [15:0] row_start,       row_start_next;
  logic        display_on,      display_on_next;
  logic        cursor_line_on,  cursor_line_on_next;
  logic        cursor_blink_on, cursor_blink_on_next;
  logic [4:0]  frame_counter,   frame_counter_next;
  logic [3:0]  status_bits,     status_bits_next;

  logic        interlace;
  logic [15:0] start_addr;
  logic [15:0] step;

  function automatic logic scan_match(input logic [4:0] scan, input logic [7:0] target,
                                      input logic il);
    return ({3'b000, scan} == target) || (il && ({3'b000, scan} == {1'b0, target[7:1]}));
  endfunction

  assign interlace  = cfg.r8[1:0] == 2'b11;
  assign start_addr = cfg.wide_mode ? {cfg.r12, cfg.r13} : ({cfg.r12, cfg.r13} & StartMask);
  assign step       = cfg.wide_mode ? {7'b0, cfg.r1, 1'b0} : {8'b0, cfg.r1};

  // Half-line update: end-of-display phase, then end-of-line phase
  always_comb begin
    line_phase_next      = line_phase;
    scan_line_next       = scan_line;
    char_row_next        = char_row;
    adjust_left_next     = adjust_left;
    vsync_left_next      = vsync_left;
    char_address_next    = char_address;
    row_start_next       = row_start;
    display_on_next      = display_on;
    cursor_line_on_next  = cursor_line_on;
    cursor_blink_on_next = cursor_blink_on;
    frame_counter_next   = frame_counter;
    status_bits_next     = status_bits;
    if (tick_en) begin
      if (!line_phase) begin
        status_bits_next[0] = 1'b1;
        line_phase_next     = 1'b1;
        if (display_on) begin
          char_address_next = char_address + step;
        end
        if (char_row == cfg.r7 && scan_line == 5'd0) begin
          status_bits_next[3] = 1'b1;
        end
      end else begin
        if (display_on) begin
          status_bits_next[0] = 1'b0;
        end
        line_phase_next = 1'b0;
        if (vsync_left != 5'd0) begin
          vsync_left_next = vsync_left - 5'd1;
          if (vsync_left_next == 5'd0) begin
            status_bits_next[3] = 1'b0;
          end
        end
        if (scan_match(scan_line, {3'b000, cfg.r11[4:0]}, interlace)) begin
          cursor_line_on_next = 1'b0;
        end
        if (adjust_left != 5'd0) begin
          // Vertical adjust lines
          scan_line_next    = scan_line + 5'd1;
          char_address_next = row_start;
          adjust_left_next  = adjust_left - 5'd1;
          if (adjust_left_next == 5'd0) begin
            display_on_next   = 1'b1;
            char_address_next = start_addr;
            row_start_next    = start_addr;
            scan_line_next    = 5'd0;
          end
        end else if (scan_match(scan_line, cfg.r9, interlace)) begin
          // End of character row
          row_start_next = char_address;
          scan_line_next = 5'd0;
          char_row_next  = char_row + 8'd1;
          if (char_row_next == cfg.r6) begin
            display_on_next = 1'b0;
          end
          if (char_row == cfg.r4) begin
            char_row_next    = 8'd0;
            adjust_left_next = cfg.r5[4:0];
            if (cfg.r5[4:0] == 5'd0) begin
              display_on_next   = 1'b1;
              char_address_next = start_addr;
              row_start_next    = start_addr;
            end
            if ((cfg.r10 & BlinkSelMsk) == BlinkOff) begin
              cursor_blink_on_next = 1'b0;
            end else begin
              cursor_blink_on_next = frame_counter[4];
            end
          end
          if (char_row_next == cfg.r7) begin
            display_on_next    = 1'b0;
            vsync_left_next    = VsyncLines;
            frame_counter_next = frame_counter + 5'd1;
          end
        end else begin
          scan_line_next    = scan_line + 5'd1;
          char_address_next = row_start;
        end
        if (scan_match(scan_line_next, {3'b000, cfg.r10[4:0]}, interlace)) begin
          cursor_line_on_next = 1'b1;
        end
      end
    end
  end

  // Hold timing state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_phase      <= 1'b0;
      scan_line       <= '0;
      char_row        <= '0;
      adjust_left     <= '0;
      vsync_left      <= '0;
      char_address    <= '0;
      row_start       <= '0;
      display_on      <= 1'b0;
      cursor_line_on  <= 1'b0;
      cursor_blink_on <= 1'b0;
      frame_counter   <= '0;
      status_bits     <= '0;
    end else begin
      line_phase      <= line_phase_next;
      scan_line       <= scan_line_next;
      char_row        <= char_row_next;
      adjust_left     <= adjust_left_next;
      vsync_left      <= vsync_left_next;
      char_address    <= char_address_next;
      row_start       <= row_start_next;
      display_on      <= display_on_next;
      cursor_line_on  <= cursor_line_on_next;
      cursor_blink_on <= cursor_blink_on_next;
      frame_counter   <= frame_counter_next;
      status_bits     <= status_bits_next;
    end
  end

  assign status_cur         = status_bits;
  assign nxt.display_on     = display_on_next;
  assign nxt.scan_line      = scan_line_next;
  assign nxt.char_row       = char_row_next;
  assign nxt.char_address   = char_address_next;
  assign nxt.cursor_visible = cursor_line_on_next && cursor_blink_on_next;
  assign nxt.status_bits    = status_bits_next;

  // Counters move only on ticks
  a_hold_without_tick: assert property (@(posedge clk) disable iff (rst)
    !tick_en |=> $stable(scan_line) && $stable(char_row) && $stable(char_address))
    else $error("timing state changed without a tick");

  // Each tick flips the phase
  a_phase_toggle: assert property (@(posedge clk) disable iff (rst)
    tick_en |=> line_phase != $past(line_phase))
    else $error("line phase did not toggle");

  // End-of-display phase flags display inactive
  a_inactive_flag: assert property (@(posedge clk) disable iff (rst)
    tick_en && !line_phase |=> status_bits[0])
    else $error("display inactive bit not set");

  // Vsync countdown never reloads above its line count
  a_vsync_bound: assert property (@(posedge clk) disable iff (rst)
    vsync_left <= VsyncLines)
    else $error("vsync countdown out of range");

endmodule

// File: design/crtc_vertical_timing_regs.sv
`timescale 1ns / 1ps
// Path: a request enters the input register when it is accepted, its result is loaded
//   into the result register when the input stage fires, and is held there until taken.
// Throughput: one request per cycle; the input register reloads whenever the result
//   register is empty or being taken.
// Reset (rst, synchronous): clears the register file, indexes, counters and both stages.
module crtc_vertical_timing_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] port,
  input  logic [7:0]  value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        display_enable,
  output logic [4:0]  row_scan,
  output logic [7:0]  row_count,
  output logic [15:0] memory_address,
  output logic        cursor_visible,
  output logic [3:0]  status
);
  import cvt_pkg::*;

  logic            in_q_valid;
  logic [1:0]      kind_q;
  logic [15:0]     port_q;
  logic [7:0]      value_q;
  logic            advance;
  logic            fire;
  logic            tick_en;
  logic            wr_en;
  cfg_t            cfg;
  timing_t         tim_next;
  logic [IdxW-1:0] crtc_index;
  logic [7:0]      reg_rd;
  logic [3:0]      status_cur;
  logic [7:0]      rd_byte;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_q_valid && !advance;
  assign fire     = in_q_valid && advance;
  assign tick_en  = fire && (kind_q == KIND_TICK);
  assign wr_en    = fire && (kind_q == KIND_WRITE);

  // Capture an incoming request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      kind_q  <= kind;
      port_q  <= port;
      value_q <= value;
    end
  end

  cvt_regfile u_regfile (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .port       (port_q),
    .value      (value_q),
    .cfg        (cfg),
    .crtc_index (crtc_index),
    .rd_data    (reg_rd)
  );

  cvt_timing u_timing (
    .clk        (clk),
    .rst        (rst),
    .tick_en    (tick_en),
    .cfg        (cfg),
    .status_cur (status_cur),
    .nxt        (tim_next)
  );

  // Decode a bus read
  always_comb begin
    rd_byte = 8'h00;
    if (kind_q == KIND_READ) begin
      case (port_q)
        PortIndex:  rd_byte = {3'b000, crtc_index};
        PortData:   rd_byte = reg_rd;
        PortStatus: rd_byte = {4'b0000, status_cur};
        default:    rd_byte = 8'hff;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_data      <= rd_byte;
      display_enable <= tim_next.display_on;
      row_scan       <= tim_next.scan_line;
      row_count      <= tim_next.char_row;
      memory_address <= tim_next.char_address;
      cursor_visible <= tim_next.cursor_visible;
      status         <= tim_next.status_bits;
    end
  end

  // A request in the input stage lands in the result register once it moves
  a_fire_lands: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed request did not produce a result");

  // Writes and ticks are exclusive
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    !(tick_en && wr_en))
    else $error("tick and write in the same cycle");

  // A held result keeps its request until taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !fire)
    else $error("result overwritten while stalled");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cvt_pkg::*;

  // Kind code outside the defined set: the block must leave its state alone
  localparam logic [1:0] KindNone = 2'd3;

  // Controller register indexes used by the vertical timing and by the masking tests
  localparam logic [4:0] RegHorizDisp    = 5'd1;
  localparam logic [4:0] RegVertTotal    = 5'd4;
  localparam logic [4:0] RegVertAdjust   = 5'd5;
  localparam logic [4:0] RegVertDisp     = 5'd6;
  localparam logic [4:0] RegVsyncPos     = 5'd7;
  localparam logic [4:0] RegInterlace    = 5'd8;
  localparam logic [4:0] RegMaxScan      = 5'd9;
  localparam logic [4:0] RegCursorStart  = 5'd10;
  localparam logic [4:0] RegCursorEnd    = 5'd11;
  localparam logic [4:0] RegStartHi      = 5'd12;
  localparam logic [4:0] RegStartLo      = 5'd13;
  localparam logic [4:0] RegCursorHi     = 5'd14;
  localparam logic [4:0] RegLastWritable = 5'd17;
  localparam logic [4:0] RegUnused       = 5'd31;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] port;
    logic [7:0]  value;
  } bus_req_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        disp;
    logic [4:0]  scan;
    logic [7:0]  row;
    logic [15:0] addr;
    logic        cursor;
    logic [3:0]  stat;
  } scan_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [15:0] port;
  logic [7:0]  value;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  read_data;
  logic        display_enable;
  logic [4:0]  row_scan;
  logic [7:0]  row_count;
  logic [15:0] memory_address;
  logic        cursor_visible;
  logic [3:0]  status;

  crtc_vertical_timing_regs dut (.*);

  // Timing state mirror
  logic [7:0]  tm_regs [0:31];
  logic [4:0]  tm_index;
  logic [4:0]  tm_array_index;
  logic        tm_wide;
  logic        tm_phase;
  logic [4:0]  tm_scan;
  logic [7:0]  tm_row;
  logic [4:0]  tm_adjust;
  logic [4:0]  tm_vsync;
  logic [15:0] tm_addr;
  logic [15:0] tm_row_base;
  logic        tm_disp;
  logic        tm_cur_line;
  logic        tm_cur_blink;
  logic [4:0]  tm_frames;
  logic [3:0]  tm_status;

  bus_req_t     pending_reqs [$];
  scan_result_t awaited_results [$];
  bus_req_t     next_req;
  scan_result_t want;
  int           req_count;
  int           mismatch_count;
  int           gap_left;
  int           stall_left;
  bit           quiet_in;
  bit           quiet_out;

  always #6 clk = ~clk;

  function automatic logic [7:0] writable_bits(logic [4:0] idx);
    case (idx)
      RegInterlace:                          return 8'hf3;
      RegCursorStart:                        return 8'h7f;
      RegStartHi, RegCursorHi:               return 8'h3f;
      RegVertAdjust, RegMaxScan, RegCursorEnd: return 8'h1f;
      default: return (idx <= RegLastWritable) ? 8'hff : 8'h00;
    endcase
  endfunction

  // Scan line compare; in interlace mode half the target matches too
  function automatic logic scan_hits(logic [7:0] target);
    logic interlace;
    interlace = (tm_regs[RegInterlace][1:0] == 2'b11);
    return ({3'b000, tm_scan} == target) ||
           (interlace && {3'b000, tm_scan} == (target >> 1));
  endfunction

  function automatic logic [15:0] frame_origin();
    logic [15:0] a;
    a = {tm_regs[RegStartHi], tm_regs[RegStartLo]};
    return tm_wide ? a : (a & StartMask);
  endfunction

  task automatic reset_timing_model();
    for (int i = 0; i < 32; i++) tm_regs[i] = 8'h00;
    tm_index = '0;
    tm_array_index = '0;
    tm_wide = 1'b0;
    tm_phase = 1'b0;
    tm_scan = '0;
    tm_row = '0;
    tm_adjust = '0;
    tm_vsync = '0;
    tm_addr = '0;
    tm_row_base = '0;
    tm_disp = 1'b0;
    tm_cur_line = 1'b0;
    tm_cur_blink = 1'b0;
    tm_frames = '0;
    tm_status = '0;
  endtask

  // Apply one request to the mirror and return the state it leaves behind
  function automatic scan_result_t advance_timing(logic [1:0] k, logic [15:0] p,
                                                  logic [7:0] v);
    scan_result_t res;
    logic [15:0]  step;
    logic [7:0]   prev_row;
    res.read_byte = 8'h00;
    case (k)
      KIND_TICK: begin
        if (!tm_phase) begin
          // end of display part of the line
          tm_status[0] = 1'b1;
          tm_phase = 1'b1;
          if (tm_disp) begin
            step = {8'h00, tm_regs[RegHorizDisp]};
            if (tm_wide) step = step << 1;
            tm_addr = tm_addr + step;
          end
          if (tm_row == tm_regs[RegVsyncPos] && tm_scan == 5'd0) tm_status[3] = 1'b1;
        end else begin
          // end of line: advance the vertical counters
          if (tm_disp) tm_status[0] = 1'b0;
          tm_phase = 1'b0;
          if (tm_vsync != 5'd0) begin
            tm_vsync = tm_vsync - 5'd1;
            if (tm_vsync == 5'd0) tm_status[3] = 1'b0;
          end
          if (scan_hits({3'b000, tm_regs[RegCursorEnd][4:0]})) tm_cur_line = 1'b0;
          if (tm_adjust != 5'd0) begin
            tm_scan = tm_scan + 5'd1;
            tm_addr = tm_row_base;
            tm_adjust = tm_adjust - 5'd1;
            if (tm_adjust == 5'd0) begin
              tm_disp = 1'b1;
              tm_row_base = frame_origin();
              tm_addr = tm_row_base;
              tm_scan = 5'd0;
            end
          end else if (scan_hits(tm_regs[RegMaxScan])) begin
            prev_row = tm_row;
            tm_row_base = tm_addr;
            tm_scan = 5'd0;
            tm_row = tm_row + 8'd1;
            if (tm_row == tm_regs[RegVertDisp]) tm_disp = 1'b0;
            if (prev_row == tm_regs[RegVertTotal]) begin
              tm_row = 8'd0;
              tm_adjust = tm_regs[RegVertAdjust][4:0];
              if (tm_adjust == 5'd0) begin
                tm_disp = 1'b1;
                tm_row_base = frame_origin();
                tm_addr = tm_row_base;
              end
              if ((tm_regs[RegCursorStart] & BlinkSelMsk) == BlinkOff) tm_cur_blink = 1'b0;
              else tm_cur_blink = tm_frames[4];
            end
            if (tm_row == tm_regs[RegVsyncPos]) begin
              tm_disp = 1'b0;
              tm_vsync = VsyncLines;
              tm_frames = tm_frames + 5'd1;
            end
          end else begin
            tm_scan = tm_scan + 5'd1;
            tm_addr = tm_row_base;
          end
          if (scan_hits({3'b000, tm_regs[RegCursorStart][4:0]})) tm_cur_line = 1'b1;
        end
      end
      KIND_WRITE: begin
        case (p)
          PortIndex: tm_index = v[4:0];
          PortData: begin
            if (int'(tm_index) < CrtcRegs) tm_regs[tm_index] = v & writable_bits(tm_index);
          end
          PortStatus: tm_array_index = v[4:0];
          PortArray: begin
            if (tm_array_index == ArrayWide) tm_wide = v[0];
          end
          default: ;
        endcase
      end
      KIND_READ: begin
        case (p)
          PortIndex:  res.read_byte = {3'b000, tm_index};
          PortData:   res.read_byte = (int'(tm_index) < CrtcRegs) ? tm_regs[tm_index] : 8'h00;
          PortStatus: res.read_byte = {4'h0, tm_status};
          default:    res.read_byte = 8'hff;
        endcase
      end
      default: ;
    endcase
    res.disp = tm_disp;
    res.scan = tm_scan;
    res.row = tm_row;
    res.addr = tm_addr;
    res.cursor = tm_cur_line & tm_cur_blink;
    res.stat = tm_status;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] bus_port(int sel);
    case (sel)
      0:       return PortIndex;
      1:       return PortData;
      2:       return PortStatus;
      default: return PortArray;
    endcase
  endfunction

  task automatic queue_req(logic [1:0] k, logic [15:0] p, logic [7:0] v);
    bus_req_t r;
    r.kind = k;
    r.port = p;
    r.value = v;
    pending_reqs.push_back(r);
    // writes to unmapped ports and unknown kinds leave the block untouched
    if (k != KindNone && !(k == KIND_WRITE && p != PortIndex && p != PortData &&
                           p != PortStatus && p != PortArray))
      req_count++;
  endtask

  task automatic queue_reg_write(logic [4:0] idx, logic [7:0] v);
    queue_req(KIND_WRITE, PortIndex, {3'($urandom), idx});
    queue_req(KIND_WRITE, PortData, v);
  endtask

  task automatic queue_wide(logic on);
    queue_req(KIND_WRITE, PortStatus, {3'($urandom), ArrayWide});
    queue_req(KIND_WRITE, PortArray, {7'($urandom), on});
  endtask

  // Half-line ticks with the odd bus read mixed in
  task automatic queue_ticks(int n);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0)
        queue_req(KIND_READ, bus_port($urandom_range(0, 3)), 8'($urandom));
      queue_req(KIND_TICK, 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
    if (exp_val !== act_val) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
    end
  endtask

  // Request driver: one request per slot, random gaps after each
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) awaited_results.push_back(advance_timing(kind, port, value));
      if (!in_valid || !in_stall) begin
        if ($urandom_range(0, 63) == 0) quiet_in = !quiet_in;
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          kind <= next_req.kind;
          port <= next_req.port;
          value <= next_req.value;
          in_valid <= 1'b1;
          gap_left = quiet_in ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest prediction, then pick the stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("%0t ns: result with none awaited", $time);
        end else begin
          want = awaited_results.pop_front();
          check_field("read_data", want.read_byte, read_data);
          check_field("display_enable", want.disp, display_enable);
          check_field("row_scan", want.scan, row_scan);
          check_field("row_count", want.row, row_count);
          check_field("memory_address", want.addr, memory_address);
          check_field("cursor_visible", want.cursor, cursor_visible);
          check_field("status", want.stat, status);
        end
      end
      if ($urandom_range(0, 63) == 0) quiet_out = !quiet_out;
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (quiet_out || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("crtc_vertical_timing_regs verification failed");
    $finish;
  end

  initial begin
    int  sel;
    int  rows;
    bit  long_done;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_TICK;
    port = 16'h0000;
    value = 8'h00;
    out_stall = 1'b0;
    req_count = 0;
    mismatch_count = 0;
    gap_left = 0;
    stall_left = 0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    long_done = 1'b0;
    reset_timing_model();

    // Directed: port decode, masking, unwritable register, wide mode, unknown kind
    queue_req(KIND_READ, PortIndex, 8'h00);
    queue_req(KIND_READ, 16'hffff, 8'hff);
    queue_req(KIND_READ, 16'h0000, 8'h00);
    queue_req(KIND_WRITE, 16'hffff, 8'hff);
    queue_req(KIND_WRITE, PortIndex, 8'hff);
    queue_req(KIND_WRITE, PortData, 8'hff);
    queue_req(KIND_READ, PortData, 8'h00);
    queue_req(KIND_READ, PortIndex, 8'h00);
    queue_reg_write(RegInterlace, 8'hff);
    queue_req(KIND_READ, PortData, 8'h00);
    queue_req(KIND_WRITE, PortStatus, 8'he5);
    queue_req(KIND_WRITE, PortArray, 8'hff);
    queue_req(KIND_READ, PortStatus, 8'h00);
    queue_req(KindNone, 16'hffff, 8'hff);
    queue_reg_write(RegStartHi, 8'hff);
    queue_reg_write(RegStartLo, 8'hff);
    queue_ticks(6);

    // Random: mostly programmed frames run with ticks, some noise and torn sequences
    while (req_count < 500) begin
      if (!long_done && req_count >= 200) begin
        // one-line rows over a long frame: row counter and address both wrap
        queue_reg_write(RegMaxScan, 8'h00);
        queue_reg_write(RegVertAdjust, 8'h00);
        queue_reg_write(RegInterlace, 8'h00);
        queue_reg_write(RegVertDisp, 8'h00);
        queue_reg_write(RegVsyncPos, 8'hf0);
        queue_reg_write(RegHorizDisp, 8'hff);
        queue_reg_write(RegStartHi, 8'hff);
        queue_reg_write(RegStartLo, 8'hff);
        queue_wide(1'b1);
        queue_reg_write(RegVertTotal, 8'h00);
        queue_ticks(12);
        queue_reg_write(RegVertTotal, 8'h01);
        queue_ticks(2);
        queue_reg_write(RegVertTotal, 8'h00);
        queue_ticks(520);
        long_done = 1'b1;
      end
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        rows = $urandom_range(0, 6);
        queue_reg_write(RegHorizDisp, 8'($urandom));
        queue_reg_write(RegVertTotal, 8'(rows));
        queue_reg_write(RegVertAdjust, {3'($urandom), 5'($urandom_range(0, 4))});
        queue_reg_write(RegVertDisp, 8'($urandom_range(0, rows + 1)));
        queue_reg_write(RegVsyncPos, 8'($urandom_range(0, rows)));
        queue_reg_write(RegInterlace, 8'($urandom));
        queue_reg_write(RegMaxScan, {3'($urandom), 5'($urandom_range(0, 3))});
        queue_reg_write(RegCursorStart, {3'($urandom), 5'($urandom_range(0, 3))});
        queue_reg_write(RegCursorEnd, {3'($urandom), 5'($urandom_range(0, 3))});
        queue_reg_write(RegStartHi, 8'($urandom));
        queue_reg_write(RegStartLo, 8'($urandom));
        if ($urandom_range(0, 1) == 1) queue_wide(1'($urandom));
        queue_ticks($urandom_range(30, 90));
      end else if (sel < 8) begin
        repeat ($urandom_range(3, 10)) begin
          queue_req(2'($urandom),
                    ($urandom_range(0, 1) == 1) ? bus_port($urandom_range(0, 3))
                                                : 16'($urandom),
                    8'($urandom));
        end
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            queue_req(KIND_WRITE, PortIndex, 8'($urandom));
            queue_req(KIND_READ, PortData, 8'($urandom));
          end
          1: begin
            queue_req(KIND_WRITE, PortStatus, 8'($urandom));
            queue_req(KIND_WRITE, PortArray, 8'($urandom));
          end
          default: queue_req(KIND_WRITE, PortData, 8'($urandom));
        endcase
      end
    end
    queue_reg_write(RegUnused, 8'hff);
    queue_req(KIND_READ, PortData, 8'h00);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything accepted, every result back, then a short settle
    while (pending_reqs.size() != 0 || in_valid) @(negedge clk);
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("crtc_vertical_timing_regs verification clean");
    end else begin
      $display("crtc_vertical_timing_regs verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/cvt_pkg.sv
design/cvt_regfile.sv
design/cvt_timing.sv
design/crtc_vertical_timing_regs.sv
tb/sv/tb_top.sv
